// ===== rtl/core/tween_pkg.sv =====
// shared types, constants and the control program of the motion tween unit
`default_nettype none

package tween_pkg;

  // coordinate and step counter widths
  localparam int unsigned COORD_W = 16;
  localparam int unsigned STEP_W  = 17;

  // pi/2 in Q2.30, used to place the quarter-wave samples
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_START_X     = 3'd0,
    REG_START_Y     = 3'd1,
    REG_END_X       = 3'd2,
    REG_END_Y       = 3'd3,
    REG_STEP_COUNT  = 3'd4,
    REG_EASING_MODE = 3'd5
  } reg_index_t;

  // datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_LOAD     = 4'd0,
    OP_DIV_INIT = 4'd1,
    OP_DIV_STEP = 4'd2,
    OP_IDX      = 4'd3,
    OP_ROM      = 4'd4,
    OP_FSEL     = 4'd5,
    OP_MULX     = 4'd6,
    OP_SUMX     = 4'd7,
    OP_MULY     = 4'd8,
    OP_SUMY     = 4'd9,
    OP_FINISH   = 4'd10
  } op_t;

  // conditions for holding a step or jumping
  typedef enum logic [2:0] {
    C_NEVER       = 3'd0,
    C_ALWAYS      = 3'd1,
    C_NO_ACCEPT   = 3'd2,
    C_PAST_END    = 3'd3,
    C_DIV_BUSY    = 3'd4,
    C_OUT_BLOCKED = 3'd5
  } cond_t;

  localparam int unsigned PC_W = 4;

  // program addresses
  localparam logic [PC_W-1:0] STEP_WAIT   = 4'd0;
  localparam logic [PC_W-1:0] STEP_CHECK  = 4'd1;
  localparam logic [PC_W-1:0] STEP_DIV    = 4'd2;
  localparam logic [PC_W-1:0] STEP_IDX    = 4'd3;
  localparam logic [PC_W-1:0] STEP_ROM    = 4'd4;
  localparam logic [PC_W-1:0] STEP_FSEL   = 4'd5;
  localparam logic [PC_W-1:0] STEP_MULX   = 4'd6;
  localparam logic [PC_W-1:0] STEP_SUMX   = 4'd7;
  localparam logic [PC_W-1:0] STEP_MULY   = 4'd8;
  localparam logic [PC_W-1:0] STEP_SUMY   = 4'd9;
  localparam logic [PC_W-1:0] STEP_FINISH = 4'd10;

  // control word: stay while wait_on holds, else jump if jump_on holds, else advance
  typedef struct packed {
    op_t             op;
    cond_t           wait_on;
    cond_t           jump_on;
    logic [PC_W-1:0] target;
  } ucode_t;

  // control program
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{op: OP_LOAD, wait_on: C_NEVER, jump_on: C_ALWAYS, target: STEP_WAIT};
    case (pc)
      STEP_WAIT:   w = '{op: OP_LOAD,     wait_on: C_NO_ACCEPT,   jump_on: C_NEVER,
                         target: STEP_WAIT};
      STEP_CHECK:  w = '{op: OP_DIV_INIT, wait_on: C_NEVER,       jump_on: C_PAST_END,
                         target: STEP_FINISH};
      STEP_DIV:    w = '{op: OP_DIV_STEP, wait_on: C_DIV_BUSY,    jump_on: C_NEVER,
                         target: STEP_WAIT};
      STEP_IDX:    w = '{op: OP_IDX,      wait_on: C_NEVER,       jump_on: C_NEVER,
                         target: STEP_WAIT};
      STEP_ROM:    w = '{op: OP_ROM,      wait_on: C_NEVER,       jump_on: C_NEVER,
                         target: STEP_WAIT};
      STEP_FSEL:   w = '{op: OP_FSEL,     wait_on: C_NEVER,       jump_on: C_NEVER,
                         target: STEP_WAIT};
      STEP_MULX:   w = '{op: OP_MULX,     wait_on: C_NEVER,       jump_on: C_NEVER,
                         target: STEP_WAIT};
      STEP_SUMX:   w = '{op: OP_SUMX,     wait_on: C_NEVER,       jump_on: C_NEVER,
                         target: STEP_WAIT};
      STEP_MULY:   w = '{op: OP_MULY,     wait_on: C_NEVER,       jump_on: C_NEVER,
                         target: STEP_WAIT};
      STEP_SUMY:   w = '{op: OP_SUMY,     wait_on: C_NEVER,       jump_on: C_NEVER,
                         target: STEP_WAIT};
      STEP_FINISH: w = '{op: OP_FINISH,   wait_on: C_OUT_BLOCKED, jump_on: C_ALWAYS,
                         target: STEP_WAIT};
      default:     w = '{op: OP_LOAD,     wait_on: C_NEVER,       jump_on: C_ALWAYS,
                         target: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/two_mode_motion_tween_unit.sv =====
// motion tween unit: linear or quarter-sine interpolation between two points
//
//  channel  | dir | handshake          | contents
//  ---------+-----+--------------------+--------------------------------------------
//  s_       | in  | s_tvalid/s_tready  | tdata[0] restart, one tick per transaction
//  m_       | out | m_tvalid/m_tready  | tdata out_x, out_y; tlast done_res
//  cfg_     | in  | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
//  a tick's result is set by the bit-serial divide k/n and the shared multiplier used
//  for x then y; a tick past the end point skips both and goes from the check step
//  straight to the finishing step
//  ticks are taken one at a time; the next is accepted as soon as the result is
//  written to the output register, even while that register still waits
//  a stalled output holds the program at its last step
//  synchronous reset clears the program counter, step counter, output valid and
//  the configuration registers, with the step count set to one; no clearing pass is needed
`default_nettype none

module two_mode_motion_tween_unit #(
  parameter int unsigned FRACTION_BITS    = 16,
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input ticks
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,    // [0] restart, [7:1] zero
  // results
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,    // [15:0] out_x, [31:16] out_y
  output logic             m_tlast,    // done_res
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int unsigned F      = FRACTION_BITS;
  localparam int unsigned Q_W    = F + 1;
  localparam int unsigned IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned IDXP_W = Q_W + IDX_W;
  localparam int unsigned CNT_W  = $clog2(F + 1);
  localparam int unsigned PROD_W = F + 19;
  localparam int unsigned SUM_W  = F + 20;
  localparam int unsigned CW     = tween_pkg::COORD_W;
  localparam int unsigned SW     = tween_pkg::STEP_W;

  // quarter-wave sample: Taylor series to x^13 in Q2.30, rounded to Q1.F, capped at 1.0
  function automatic logic [Q_W-1:0] sine_entry(input int unsigned i);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    longint      r;
    x    = (64'(tween_pkg::HALF_PI_Q30) * 64'(i)) / SINE_TABLE_DEPTH;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 156;
    sum  = sum + longint'(term);
    if (sum < 0) sum = 0;
    r = (sum + (longint'(1) << (29 - F))) >>> (30 - F);
    if (r > (longint'(1) << F)) r = longint'(1) << F;
    return r[Q_W-1:0];
  endfunction

  // sine table, filled at elaboration
  logic [Q_W-1:0] sine_rom [0:SINE_TABLE_DEPTH];
  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_sine
    localparam logic [Q_W-1:0] ENTRY = sine_entry(g);
    assign sine_rom[g] = ENTRY;
  end

  // configuration registers
  logic [CW-1:0] start_x, start_y, end_x, end_y, step_count;
  logic          easing_mode;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_x     <= '0;
      start_y     <= '0;
      end_x       <= '0;
      end_y       <= '0;
      step_count  <= CW'(1);
      easing_mode <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        tween_pkg::REG_START_X:     start_x     <= cfg_data;
        tween_pkg::REG_START_Y:     start_y     <= cfg_data;
        tween_pkg::REG_END_X:       end_x       <= cfg_data;
        tween_pkg::REG_END_Y:       end_y       <= cfg_data;
        tween_pkg::REG_STEP_COUNT:  step_count  <= cfg_data;
        tween_pkg::REG_EASING_MODE: easing_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer state
  logic [tween_pkg::PC_W-1:0] pc, pc_next;
  tween_pkg::ucode_t          uw;
  logic                       wait_hit, jump_hit;

  // datapath registers
  logic [SW-1:0]     step_index, k_work;
  logic              past_end;
  logic [CW-1:0]     rem;
  logic [F-1:0]      quo;
  logic              q_top;
  logic [CNT_W-1:0]  div_cnt;
  logic [IDX_W-1:0]  idx_reg;
  logic [Q_W-1:0]    rom_q, frac;
  logic signed [PROD_W-1:0] prod;
  logic [CW-1:0]     px, py;

  // combinational helpers
  logic [CW-1:0]     n_eff;
  logic              accept, out_blocked, k_over;
  logic [CW:0]       rem_dbl;
  logic              rem_ge;
  logic [Q_W-1:0]    q_val;
  logic [IDXP_W-1:0] idx_full;
  logic [IDX_W:0]    idx_sh;
  logic              sel_y;
  logic [CW-1:0]     bs, be;
  logic signed [CW:0]       diff;
  logic signed [PROD_W-1:0] mul_res;
  logic signed [SUM_W-1:0]  base_sh, v, v_adj;
  logic [CW-1:0]     blend_res;
  logic              done_now, force_end;

  assign n_eff       = (step_count == '0) ? CW'(1) : step_count;
  assign s_tready    = (pc == tween_pkg::STEP_WAIT);
  assign accept      = s_tvalid && s_tready;
  assign out_blocked = m_tvalid && !m_tready;
  assign k_over      = k_work > {1'b0, n_eff};
  assign uw          = tween_pkg::ucode_rom(pc);

  // condition select
  function automatic logic cond_eval(input tween_pkg::cond_t c, input logic no_acc,
                                     input logic over, input logic busy,
                                     input logic blocked);
    logic r;
    case (c)
      tween_pkg::C_NEVER:       r = 1'b0;
      tween_pkg::C_ALWAYS:      r = 1'b1;
      tween_pkg::C_NO_ACCEPT:   r = no_acc;
      tween_pkg::C_PAST_END:    r = over;
      tween_pkg::C_DIV_BUSY:    r = busy;
      tween_pkg::C_OUT_BLOCKED: r = blocked;
      default:                  r = 1'b0;
    endcase
    return r;
  endfunction

  // next program address
  always_comb begin
    wait_hit = cond_eval(uw.wait_on, !accept, k_over, div_cnt != CNT_W'(1), out_blocked);
    jump_hit = cond_eval(uw.jump_on, !accept, k_over, div_cnt != CNT_W'(1), out_blocked);
    if (wait_hit)      pc_next = pc;
    else if (jump_hit) pc_next = uw.target;
    else               pc_next = pc + tween_pkg::PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) pc <= tween_pkg::STEP_WAIT;
    else     pc <= pc_next;
  end

  // restoring divide step
  assign rem_dbl = {rem, 1'b0};
  assign rem_ge  = rem_dbl >= {1'b0, n_eff};
  assign q_val   = {q_top, quo};

  // table index: round(q * depth / 2^F), capped at depth
  assign idx_full = IDXP_W'(q_val) * IDXP_W'(SINE_TABLE_DEPTH)
                  + (IDXP_W'(1) << (F - 1));
  assign idx_sh   = idx_full[IDXP_W-1:F];

  // shared blend unit: start + f * (end - start), truncated toward zero
  assign sel_y     = (uw.op == tween_pkg::OP_MULY) || (uw.op == tween_pkg::OP_SUMY);
  assign bs        = sel_y ? start_y : start_x;
  assign be        = sel_y ? end_y : end_x;
  assign diff      = $signed({be[CW-1], be}) - $signed({bs[CW-1], bs});
  assign mul_res   = $signed({1'b0, frac}) * diff;
  assign base_sh   = SUM_W'($signed(bs)) <<< F;
  assign v         = base_sh + SUM_W'(prod);
  assign v_adj     = v + (v[SUM_W-1] ? SUM_W'((SUM_W'(1) << F) - SUM_W'(1)) : SUM_W'(0));
  assign blend_res = v_adj[F+CW-1:F];

  // completion
  assign done_now  = !past_end && (k_work == {1'b0, n_eff});
  assign force_end = past_end || (done_now && easing_mode);

  // datapath operations
  always_ff @(posedge clk) begin
    case (uw.op)
      tween_pkg::OP_LOAD: begin
        if (accept) k_work <= s_tdata[0] ? '0 : step_index;
      end
      tween_pkg::OP_DIV_INIT: begin
        past_end <= k_over;
        q_top    <= (k_work == {1'b0, n_eff});
        rem      <= (k_work == {1'b0, n_eff}) ? '0 : k_work[CW-1:0];
        quo      <= '0;
        div_cnt  <= CNT_W'(F);
      end
      tween_pkg::OP_DIV_STEP: begin
        if (div_cnt != '0) begin
          rem     <= rem_ge ? rem_dbl[CW-1:0] - n_eff : rem_dbl[CW-1:0];
          quo     <= {quo[F-2:0], rem_ge};
          div_cnt <= div_cnt - CNT_W'(1);
        end
      end
      tween_pkg::OP_IDX: begin
        idx_reg <= (idx_sh > (IDX_W+1)'(SINE_TABLE_DEPTH)) ? IDX_W'(SINE_TABLE_DEPTH)
                                                           : idx_sh[IDX_W-1:0];
      end
      tween_pkg::OP_ROM:  rom_q <= sine_rom[idx_reg];
      tween_pkg::OP_FSEL: frac  <= easing_mode ? rom_q : q_val;
      tween_pkg::OP_MULX: prod  <= mul_res;
      tween_pkg::OP_SUMX: px    <= blend_res;
      tween_pkg::OP_MULY: prod  <= mul_res;
      tween_pkg::OP_SUMY: py    <= blend_res;
      default: ;
    endcase
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step_index <= '0;
    end else if (uw.op == tween_pkg::OP_FINISH && !out_blocked && !past_end) begin
      step_index <= k_work + SW'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (uw.op == tween_pkg::OP_FINISH && !out_blocked) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.op == tween_pkg::OP_FINISH && !out_blocked) begin
      m_tdata <= force_end ? {end_y, end_x} : {py, px};
      m_tlast <= done_now;
    end
  end

  // checks
  a_div_active: assert property (@(posedge clk) disable iff (rst)
    (pc == tween_pkg::STEP_DIV) |-> (div_cnt != '0))
    else $error("divide step entered with no bits left");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (pc == tween_pkg::STEP_DIV) |-> (rem < n_eff))
    else $error("divide remainder not below step count");

  a_finish_return: assert property (@(posedge clk) disable iff (rst)
    (pc == tween_pkg::STEP_FINISH && !out_blocked) |=> (pc == tween_pkg::STEP_WAIT))
    else $error("program did not return to wait after result");

  a_sine_end: assert property (@(posedge clk) disable iff (rst)
    (pc == tween_pkg::STEP_FINISH && !out_blocked && done_now && easing_mode)
      |=> (m_tdata == {end_y, end_x}))
    else $error("sine mode last step not at end point");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    pc <= tween_pkg::STEP_FINISH)
    else $error("program counter outside program");

endmodule

`default_nettype wire

// ===== bench/two_mode_motion_tween_unit_tb.sv =====
// self-checking bench for the two-mode motion tween unit: directed table plus random tick runs
module two_mode_motion_tween_unit_tb;

  localparam int unsigned FRAC       = 16;
  localparam int unsigned SINE_DEPTH = 1024;
  localparam longint unsigned HALF_PI_FX = 64'd1686629713;
  localparam int TICK_TARGET   = 800;
  localparam int QUIET_TICKS   = 150;
  localparam int HOLD_LEN      = 400;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic        done;
  } tween_point_t;

  typedef enum logic {ROW_CFG, ROW_TICK} row_kind_t;

  // one row of the directed plan: a register write or a tick with optional known answer
  typedef struct packed {
    row_kind_t             kind;
    tween_pkg::reg_index_t idx;
    logic [15:0]           data;
    logic                  restart;
    logic                  typed;
    logic [15:0]           px;
    logic [15:0]           py;
    logic                  pdone;
  } plan_row_t;

  localparam int PLAN_LEN = 33;
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    // reset values: zero path, one step
    '{ROW_TICK, tween_pkg::REG_START_X, 16'h0000, 1'b0, 1'b1, 16'h0000, 16'h0000, 1'b0},
    '{ROW_TICK, tween_pkg::REG_START_X, 16'h0000, 1'b0, 1'b1, 16'h0000, 16'h0000, 1'b1},
    '{ROW_TICK, tween_pkg::REG_START_X, 16'h0000, 1'b0, 1'b1, 16'h0000, 16'h0000, 1'b0},
    // full-range diagonal, zero step count acts as one
    '{ROW_CFG,  tween_pkg::REG_START_X, 16'h8000, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ROW_CFG,  tween_pkg::REG_START_Y, 16'h7fff, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ROW_CFG,  tween_pkg::REG_END_X,   16'h7fff, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ROW_CFG,  tween_pkg::REG_END_Y,   16'h8000, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ROW_CFG,  tween_pkg::REG_STEP_COUNT, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ROW_TICK, tween_pkg::REG_START_X, 16'h0000, 1'b1, 1'b1, 16'h8000, 16'h7fff, 1'b0},
    '{ROW_TICK, tween_pkg::REG_START_X, 16'h0000, 1'b0, 1'b1, 16'h7fff, 16'h8000, 1'b1},
    '{ROW_TICK, tween_pkg::REG_START_X, 16'h0000, 1'b0, 1'b1, 16'h7fff, 16'h8000, 1'b0},
    // sine easing over three steps, last step snaps to the end point
    '{ROW_CFG,  tween_pkg::REG_EASING_MODE, 16'h0001, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ROW_CFG,  tween_pkg::REG_STEP_COUNT, 16'h0003, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ROW_TICK, tween_pkg::REG_START_X, 16'h0000, 1'b1, 1'b1, 16'h8000, 16'h7fff, 1'b0},
    '{ROW_TICK, tween_pkg::REG_START_X, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ROW_TICK, tween_pkg::REG_START_X, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ROW_TICK, tween_pkg::REG_START_X, 16'h0000, 1'b0, 1'b1, 16'h7fff, 16'h8000, 1'b1},
    '{ROW_TICK, tween_pkg::REG_START_X, 16'h0000, 1'b0, 1'b1, 16'h7fff, 16'h8000, 1'b0},
    // largest step count, then lowered below the current step
    '{ROW_CFG,  tween_pkg::REG_EASING_MODE, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ROW_CFG,  tween_pkg::REG_STEP_COUNT, 16'hffff, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ROW_TICK, tween_pkg::REG_START_X, 16'h0000, 1'b1, 1'b1, 16'h8000, 16'h7fff, 1'b0},
    '{ROW_TICK, tween_pkg::REG_START_X, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ROW_TICK, tween_pkg::REG_START_X, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ROW_CFG,  tween_pkg::REG_STEP_COUNT, 16'h0001, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ROW_TICK, tween_pkg::REG_START_X, 16'h0000, 1'b0, 1'b1, 16'h7fff, 16'h8000, 1'b0},
    '{ROW_TICK, tween_pkg::REG_START_X, 16'h0000, 1'b1, 1'b1, 16'h8000, 16'h7fff, 1'b0},
    // short sine run with a midpoint
    '{ROW_CFG,  tween_pkg::REG_EASING_MODE, 16'h0001, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ROW_CFG,  tween_pkg::REG_START_X, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ROW_CFG,  tween_pkg::REG_END_X,   16'h1000, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ROW_CFG,  tween_pkg::REG_STEP_COUNT, 16'h0002, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ROW_TICK, tween_pkg::REG_START_X, 16'h0000, 1'b1, 1'b1, 16'h0000, 16'h7fff, 1'b0},
    '{ROW_TICK, tween_pkg::REG_START_X, 16'h0000, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0},
    '{ROW_TICK, tween_pkg::REG_START_X, 16'h0000, 1'b0, 1'b1, 16'h1000, 16'h8000, 1'b1}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;    // [0] restart, [7:1] zero
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;           // [15:0] out_x, [31:16] out_y
  logic        m_tlast;           // done_res
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  tween_pkg::reg_index_t cfg_index = tween_pkg::REG_START_X;
  logic [15:0] cfg_data = 16'd0;

  two_mode_motion_tween_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor copy of the path registers and step counter
  logic signed [15:0] cur_start_x, cur_start_y, cur_end_x, cur_end_y;
  logic [15:0]        cur_steps;
  logic               cur_ease;
  logic [16:0]        step_k;
  longint             sine_tab [0:SINE_DEPTH];

  tween_point_t pending_pts [$];
  int errors = 0;
  int ticks_sent = 0;
  int settings_used = 0;
  int completions = 0;
  int sine_results = 0;
  int results_seen = 0;

  // receiver and sender pacing controls
  logic rx_gaps_on = 1'b1;
  int   hold_seq = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   stall_left = 0;
  bit   tx_gaps_on = 1'b1;

  // quarter-wave sample: truncated series in Q2.30, rounded to the fraction width
  function automatic longint sine_sample(input int unsigned i);
    longint unsigned ang, ang_sq, term;
    longint acc, r;
    int unsigned j;
    ang = (HALF_PI_FX * 64'(i)) / SINE_DEPTH;
    ang_sq = (ang * ang) >> 30;
    term = ang;
    acc = longint'(ang);
    for (j = 1; j <= 6; j++) begin
      term = (term * ang_sq) >> 30;
      term = term / (2 * j * (2 * j + 1));
      if (j % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    r = (acc + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
    if (r > (64'sd1 << FRAC)) r = 64'sd1 << FRAC;
    return r;
  endfunction

  // start + f * (end - start), truncated toward zero
  function automatic longint lerp_axis(input longint s, input longint e, input longint f);
    longint v;
    v = s * (64'sd1 << FRAC) + f * (e - s);
    return v / (64'sd1 << FRAC);
  endfunction

  // one tick of the tween: compute the point and advance the step counter
  function automatic tween_point_t advance_tween(input logic restart);
    tween_point_t    pt;
    longint unsigned n, q, idx;
    longint          f;
    n = (cur_steps == 16'd0) ? 64'd1 : 64'(cur_steps);
    if (restart) step_k = '0;
    pt.done = 1'b0;
    if (64'(step_k) > n) begin
      pt.x = cur_end_x;
      pt.y = cur_end_y;
    end else begin
      q = (64'(step_k) << FRAC) / n;
      if (cur_ease) begin
        idx = (q * SINE_DEPTH + (64'd1 << (FRAC - 1))) >> FRAC;
        if (idx > SINE_DEPTH) idx = SINE_DEPTH;
        f = sine_tab[idx];
        sine_results++;
      end else begin
        f = longint'(q);
      end
      pt.x = 16'(lerp_axis(cur_start_x, cur_end_x, f));
      pt.y = 16'(lerp_axis(cur_start_y, cur_end_y, f));
      if (64'(step_k) == n) begin
        pt.done = 1'b1;
        if (cur_ease) begin
          pt.x = cur_end_x;
          pt.y = cur_end_y;
        end
      end
      step_k = step_k + 17'd1;
    end
    return pt;
  endfunction

  // compare one result transaction with the oldest expectation
  task automatic check_point();
    tween_point_t want;
    results_seen++;
    if (m_tlast) completions++;
    if (pending_pts.size() == 0) begin
      $error("unexpected result x=%0d y=%0d done=%0b",
             $signed(m_tdata[15:0]), $signed(m_tdata[31:16]), m_tlast);
      errors++;
    end else begin
      want = pending_pts.pop_front();
      if (m_tdata[15:0] !== want.x) begin
        $error("out_x expected %0d got %0d", $signed(want.x), $signed(m_tdata[15:0]));
        errors++;
      end
      if (m_tdata[31:16] !== want.y) begin
        $error("out_y expected %0d got %0d", $signed(want.y), $signed(m_tdata[31:16]));
        errors++;
      end
      if (m_tlast !== want.done) begin
        $error("done_res expected %0b got %0b", want.done, m_tlast);
        errors++;
      end
    end
  endtask

  // result side: check accepted transactions, then pick next ready value
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_point();
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_LEN - 1;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (rx_gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 10) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic write_reg(input tween_pkg::reg_index_t idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      tween_pkg::REG_START_X:     cur_start_x = val;
      tween_pkg::REG_START_Y:     cur_start_y = val;
      tween_pkg::REG_END_X:       cur_end_x = val;
      tween_pkg::REG_END_Y:       cur_end_y = val;
      tween_pkg::REG_STEP_COUNT:  cur_steps = val;
      tween_pkg::REG_EASING_MODE: cur_ease = val[0];
      default: ;
    endcase
  endtask

  task automatic end_cfg();
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // offer one tick; valid stays high so back-to-back ticks need no second assignment
  task automatic send_tick(input logic restart, input logic use_typed,
                           input tween_point_t typed_pt);
    tween_point_t pt;
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, restart};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pt = advance_tween(restart);
    pending_pts.push_back(use_typed ? typed_pt : pt);
    ticks_sent++;
  endtask

  task automatic sender_gap();
    if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // drain everything outstanding before touching the registers
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_steps();
    case ($urandom_range(0, 11))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 24));
    endcase
  endfunction

  // main stimulus
  initial begin
    tween_point_t typed_pt;
    plan_row_t    row;
    row_kind_t    prev_kind;
    int           phase;
    int           run_len;
    int           n_eff;
    bit           pressing;
    logic         rs;
    for (int unsigned i = 0; i <= SINE_DEPTH; i++) sine_tab[i] = sine_sample(i);
    cur_start_x = '0;
    cur_start_y = '0;
    cur_end_x = '0;
    cur_end_y = '0;
    cur_steps = 16'd1;
    cur_ease = 1'b0;
    step_k = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    prev_kind = ROW_TICK;
    for (int r = 0; r < PLAN_LEN; r++) begin
      row = PLAN[r];
      if (row.kind == ROW_CFG) begin
        if (prev_kind != ROW_CFG) wait_idle();
        write_reg(row.idx, row.data);
      end else begin
        if (prev_kind == ROW_CFG) end_cfg();
        sender_gap();
        typed_pt = '{x: row.px, y: row.py, done: row.pdone};
        send_tick(row.restart, row.typed, typed_pt);
      end
      prev_kind = row.kind;
    end

    // random runs, each under a fresh setting
    phase = 0;
    while (ticks_sent < TICK_TARGET) begin
      if (ticks_sent > TICK_TARGET - QUIET_TICKS) begin
        tx_gaps_on = 1'b0;
        rx_gaps_on <= 1'b0;
      end
      wait_idle();
      if (phase == 0 || $urandom_range(0, 1))
        write_reg(tween_pkg::REG_START_X, pick_coord());
      if (phase == 0 || $urandom_range(0, 1))
        write_reg(tween_pkg::REG_START_Y, pick_coord());
      if (phase == 0 || $urandom_range(0, 1))
        write_reg(tween_pkg::REG_END_X, pick_coord());
      if (phase == 0 || $urandom_range(0, 1))
        write_reg(tween_pkg::REG_END_Y, pick_coord());
      if (phase == 0 || $urandom_range(0, 2) != 0)
        write_reg(tween_pkg::REG_STEP_COUNT, pick_steps());
      if (phase == 0 || $urandom_range(0, 1))
        write_reg(tween_pkg::REG_EASING_MODE, 16'($urandom));
      end_cfg();

      n_eff = (cur_steps == 16'd0) ? 1 : int'(cur_steps);
      if (n_eff > 32) run_len = $urandom_range(2, 20);
      else if ($urandom_range(0, 3) == 0) run_len = $urandom_range(1, n_eff + 4);
      else run_len = n_eff + 1 + $urandom_range(0, 3);

      // one run with the receiver held off so the unit backs up
      pressing = (phase == 3);
      if (pressing) begin
        if (run_len < 8) run_len = 8;
        hold_seq <= hold_seq + 1;
      end

      for (int i = 0; i < run_len; i++) begin
        if (i == 0) rs = ($urandom_range(0, 3) != 0);
        else rs = ($urandom_range(0, 29) == 0);
        if (!pressing) sender_gap();
        send_tick(rs, 1'b0, '0);
      end
      phase++;
    end

    // wind down
    s_tvalid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("run covered %0d ticks under %0d register settings", ticks_sent, settings_used);
    $display("%0d results checked, %0d completions, %0d sine-eased points",
             results_seen, completions, sine_results);
    if (errors == 0) begin
      $display("PASS two_mode_motion_tween_unit");
    end else begin
      $display("FAIL two_mode_motion_tween_unit");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("FAIL two_mode_motion_tween_unit");
    $finish;
  end

endmodule
